>>> src/iqs_pkg.sv
// iqs_pkg: shared types for the iterative quicksort engine
// controller states, datapath command and status structs
// no dependencies
package iqs_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_RDJ,
    ST_CMP,
    ST_SWAP,
    ST_FIN_W1,
    ST_FIN_W2,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_PLACE_A,
    WR_J_B,
    WR_HI_B,
    WR_PLACE_PIV
  } wr_sel_t;

  typedef enum logic [1:0] {
    RA_NONE,
    RA_J,
    RA_STK_HI,
    RA_K
  } ra_sel_t;

  typedef enum logic [2:0] {
    STK_NONE,
    STK_INIT,
    STK_POP,
    STK_PUSH_L,
    STK_PUSH_R
  } stk_op_t;

  typedef struct packed {
    logic    load;
    wr_sel_t wr_sel;
    ra_sel_t ra_sel;
    logic    rd_b_en;
    stk_op_t stk_op;
    logic    range_ld;
    logic    pivot_ld;
    logic    j_inc;
    logic    place_inc;
    logic    k_clr;
    logic    k_inc;
    logic    out_load;
    logic    set_clear;
  } cmd_t;

  typedef struct packed {
    logic n_gt1;
    logic sp_zero;
    logic range_ok;
    logic j_lt_hi;
    logic le;
    logic push_left;
    logic push_right;
    logic emit_last;
    logic out_busy;
  } status_t;

endpackage

>>> src/iqs_ctrl.sv
// iqs_ctrl: controller state machine for load, partition, stack and emit
// depends on iqs_pkg for state, command and status types
module iqs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_is_final,
  output logic             in_ready,
  input  iqs_pkg::status_t sts,
  output iqs_pkg::cmd_t    cmd
);

  iqs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iqs_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.wr_sel    = iqs_pkg::WR_NONE;
    cmd.ra_sel    = iqs_pkg::RA_NONE;
    cmd.stk_op    = iqs_pkg::STK_NONE;
    unique case (state_r)
      iqs_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.wr_sel = iqs_pkg::WR_LOAD;
          if (in_is_final) state_nxt = iqs_pkg::ST_INIT;
        end
      end
      iqs_pkg::ST_INIT: begin
        cmd.k_clr = 1'b1;
        if (sts.n_gt1) begin
          cmd.stk_op = iqs_pkg::STK_INIT;
          state_nxt  = iqs_pkg::ST_POP;
        end else begin
          state_nxt = iqs_pkg::ST_EM_RD;
        end
      end
      iqs_pkg::ST_POP: begin
        if (sts.sp_zero) begin
          state_nxt = iqs_pkg::ST_EM_RD;
        end else begin
          cmd.stk_op = iqs_pkg::STK_POP;
          state_nxt  = iqs_pkg::ST_RANGE;
        end
      end
      iqs_pkg::ST_RANGE: begin
        if (sts.range_ok) begin
          cmd.range_ld = 1'b1;
          cmd.ra_sel   = iqs_pkg::RA_STK_HI;
          state_nxt    = iqs_pkg::ST_PIVOT;
        end else begin
          state_nxt = iqs_pkg::ST_POP;
        end
      end
      iqs_pkg::ST_PIVOT: begin
        cmd.pivot_ld = 1'b1;
        state_nxt    = iqs_pkg::ST_RDJ;
      end
      iqs_pkg::ST_RDJ: begin
        cmd.rd_b_en = 1'b1;
        if (sts.j_lt_hi) begin
          cmd.ra_sel = iqs_pkg::RA_J;
          state_nxt  = iqs_pkg::ST_CMP;
        end else begin
          state_nxt = iqs_pkg::ST_FIN_W1;
        end
      end
      iqs_pkg::ST_CMP: begin
        if (sts.le) begin
          cmd.wr_sel = iqs_pkg::WR_PLACE_A;
          state_nxt  = iqs_pkg::ST_SWAP;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = iqs_pkg::ST_RDJ;
        end
      end
      iqs_pkg::ST_SWAP: begin
        cmd.wr_sel    = iqs_pkg::WR_J_B;
        cmd.j_inc     = 1'b1;
        cmd.place_inc = 1'b1;
        state_nxt     = iqs_pkg::ST_RDJ;
      end
      iqs_pkg::ST_FIN_W1: begin
        cmd.wr_sel = iqs_pkg::WR_HI_B;
        state_nxt  = iqs_pkg::ST_FIN_W2;
      end
      iqs_pkg::ST_FIN_W2: begin
        cmd.wr_sel = iqs_pkg::WR_PLACE_PIV;
        state_nxt  = iqs_pkg::ST_PUSH_L;
      end
      iqs_pkg::ST_PUSH_L: begin
        if (sts.push_left) cmd.stk_op = iqs_pkg::STK_PUSH_L;
        state_nxt = iqs_pkg::ST_PUSH_R;
      end
      iqs_pkg::ST_PUSH_R: begin
        if (sts.push_right) cmd.stk_op = iqs_pkg::STK_PUSH_R;
        state_nxt = iqs_pkg::ST_POP;
      end
      iqs_pkg::ST_EM_RD: begin
        cmd.ra_sel = iqs_pkg::RA_K;
        state_nxt  = iqs_pkg::ST_EM_LD;
      end
      iqs_pkg::ST_EM_LD: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          if (sts.emit_last) begin
            cmd.set_clear = 1'b1;
            state_nxt     = iqs_pkg::ST_LOAD;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = iqs_pkg::ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = iqs_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

>>> src/iqs_dpath.sv
// iqs_dpath: element store, range stack, index registers and output register
// depends on iqs_pkg for command and status types
module iqs_dpath #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iqs_pkg::cmd_t                 cmd,
  output iqs_pkg::status_t              sts,
  input  logic signed [VALUE_WIDTH-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_sorted_value,
  output logic                          out_end_of_set,
  output logic                          out_overflowed
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = 2 * IW;

  logic [VALUE_WIDTH-1:0] mem [MAX_ITEMS];
  logic [SW-1:0]          stk [MAX_ITEMS];

  logic [CW-1:0]                 load_count_r;
  logic                          overflow_r;
  logic [CW-1:0]                 sp_r;
  logic [IW-1:0]                 lo_r, hi_r, j_r, place_r, k_r;
  logic signed [VALUE_WIDTH-1:0] pivot_r;
  logic signed [VALUE_WIDTH-1:0] rd_a_r, rd_b_r;
  logic [SW-1:0]                 stk_rd_r;
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic                          out_eos_r, out_ovf_r;

  logic                   full;
  logic                   mem_we;
  logic [IW-1:0]          mem_wa;
  logic [VALUE_WIDTH-1:0] mem_wd;
  logic [IW-1:0]          ra_addr;
  logic                   stk_we;
  logic [SW-1:0]          stk_wd;
  logic [IW-1:0]          stk_lo, stk_hi;

  assign full   = (load_count_r == CW'(MAX_ITEMS));
  assign stk_lo = stk_rd_r[SW-1:IW];
  assign stk_hi = stk_rd_r[IW-1:0];

  always_comb begin
    mem_we = 1'b1;
    mem_wa = place_r;
    mem_wd = rd_a_r;
    case (cmd.wr_sel)
      iqs_pkg::WR_LOAD: begin
        mem_we = !full;
        mem_wa = load_count_r[IW-1:0];
        mem_wd = in_sample_value;
      end
      iqs_pkg::WR_PLACE_A: begin
        mem_wa = place_r;
        mem_wd = rd_a_r;
      end
      iqs_pkg::WR_J_B: begin
        mem_wa = j_r;
        mem_wd = rd_b_r;
      end
      iqs_pkg::WR_HI_B: begin
        mem_wa = hi_r;
        mem_wd = rd_b_r;
      end
      iqs_pkg::WR_PLACE_PIV: begin
        mem_wa = place_r;
        mem_wd = pivot_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    ra_addr = k_r;
    case (cmd.ra_sel)
      iqs_pkg::RA_J:      ra_addr = j_r;
      iqs_pkg::RA_STK_HI: ra_addr = stk_hi;
      default:            ra_addr = k_r;
    endcase
  end

  always_comb begin
    stk_we = sp_r < CW'(MAX_ITEMS);
    stk_wd = {lo_r, place_r - IW'(1)};
    case (cmd.stk_op)
      iqs_pkg::STK_INIT:   stk_wd = {IW'(0), IW'(load_count_r - CW'(1))};
      iqs_pkg::STK_PUSH_L: stk_wd = {lo_r, place_r - IW'(1)};
      iqs_pkg::STK_PUSH_R: stk_wd = {place_r + IW'(1), hi_r};
      default:             stk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.ra_sel != iqs_pkg::RA_NONE) rd_a_r <= mem[ra_addr];
    if (cmd.rd_b_en) rd_b_r <= mem[place_r];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[sp_r[IW-1:0]] <= stk_wd;
    if (cmd.stk_op == iqs_pkg::STK_POP) stk_rd_r <= stk[IW'(sp_r - CW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      overflow_r   <= 1'b0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) overflow_r <= 1'b1;
        else load_count_r <= load_count_r + CW'(1);
      end
      case (cmd.stk_op) inside
        iqs_pkg::STK_INIT: sp_r <= CW'(1);
        iqs_pkg::STK_POP:  sp_r <= sp_r - CW'(1);
        iqs_pkg::STK_PUSH_L,
        iqs_pkg::STK_PUSH_R: if (stk_we) sp_r <= sp_r + CW'(1);
        default: ;
      endcase
      if (cmd.set_clear) begin
        load_count_r <= '0;
        overflow_r   <= 1'b0;
        sp_r         <= '0;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range_ld) begin
      lo_r    <= stk_lo;
      hi_r    <= stk_hi;
      j_r     <= stk_lo;
      place_r <= stk_lo;
    end else begin
      if (cmd.j_inc)     j_r     <= j_r + IW'(1);
      if (cmd.place_inc) place_r <= place_r + IW'(1);
    end
    if (cmd.pivot_ld) pivot_r <= rd_a_r;
    if (cmd.k_clr) k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + IW'(1);
    if (cmd.out_load) begin
      out_value_r <= rd_a_r;
      out_eos_r   <= sts.emit_last;
      out_ovf_r   <= overflow_r;
    end
  end

  always_comb begin
    sts.n_gt1      = load_count_r > CW'(1);
    sts.sp_zero    = sp_r == '0;
    sts.range_ok   = stk_lo < stk_hi;
    sts.j_lt_hi    = j_r < hi_r;
    sts.le         = rd_a_r <= pivot_r;
    sts.push_left  = {1'b0, place_r} > ({1'b0, lo_r} + (IW + 1)'(1));
    sts.push_right = ({1'b0, place_r} + (IW + 1)'(1)) < {1'b0, hi_r};
    sts.emit_last  = (CW'(k_r) + CW'(1)) == load_count_r;
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_set   = out_eos_r;
  assign out_overflowed   = out_ovf_r;

endmodule

>>> src/iterative_quicksort_engine_core.sv
// iterative_quicksort_engine_core: top level of the iterative quicksort engine
// instantiates iqs_ctrl and iqs_dpath, uses iqs_pkg types
//
//   channel | ports                                         | transfer when
//   in      | in_valid in_ready in_sample_value in_is_final | in_valid && in_ready
//   out     | out_valid out_ready out_sorted_value           | out_valid && out_ready
//           | out_end_of_set out_overflowed                  |
//
// loading takes one cycle per value; the final value starts the sort
// sort: per range POP, RANGE, PIVOT; per compare RDJ, CMP, and SWAP when placed;
// partition end: FIN_W1, FIN_W2, PUSH_L, PUSH_R; set by the store's single write port
// emit: EM_RD then EM_LD per value from the registered store read, plus output stalls
// no input is taken from the final value until the last result is registered
// synchronous active-low reset clears load counter, stack pointer, overflow and valid flags
module iterative_quicksort_engine_core #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_sample_value,
  input  logic                          in_is_final,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_sorted_value,
  output logic                          out_end_of_set,
  output logic                          out_overflowed
);

  iqs_pkg::cmd_t    cmd;
  iqs_pkg::status_t sts;

  iqs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_final (in_is_final),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  iqs_dpath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_end_of_set   (out_end_of_set),
    .out_overflowed   (out_overflowed)
  );

endmodule
